FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers used across the core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/gpc_pkg.sv
// ----------------------------------------------------------------------------
// gpc_pkg
// Constants, types and helpers of the gate pair crossing counter.
// ----------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

   localparam int STORE_DEPTH       = 16;
   localparam int SENSORS_PER_BOARD = 8;

   localparam int BOARD_W   = 4;
   localparam int MASK_W    = 8;
   localparam int TIME_W    = 16;
   localparam int NOW_W     = 3;
   localparam int TOTAL_W   = 16;

   localparam int SENSOR_W    = $clog2(SENSORS_PER_BOARD + 1);
   localparam int MASK_IDX_W  = $clog2(MASK_W);
   localparam int STORE_IDX_W = $clog2(STORE_DEPTH);
   localparam int STORE_CNT_W = $clog2(STORE_DEPTH + 1);

   localparam int FIFO_DEPTH  = 4;
   localparam int FIFO_IDX_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

   localparam logic [TIME_W-1:0]  WINDOW_RESET = TIME_W'(500);
   localparam logic [NOW_W-1:0]   NOW_MAX      = '1;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX    = '1;

   // one per-sensor work transaction from front to back
   typedef struct packed {
      logic [BOARD_W-1:0]  board;
      logic [SENSOR_W-1:0] sensor;
      logic [TIME_W-1:0]   time_ms;
      logic                has_sensor;
      logic                last;
   } cmd_type;

   typedef struct packed {
      logic                strobe;
      logic [NOW_W-1:0]    entries_now;
      logic [NOW_W-1:0]    exits_now;
      logic [TOTAL_W-1:0]  entry_total;
      logic [TOTAL_W-1:0]  exit_total;
      logic                store_overflow;
   } rsp_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_ISSUE
   } front_state_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_APPLY
   } back_state_type;

   // mask bits that map onto real sensors of a board
   function automatic logic [MASK_W-1:0] sensor_bits();
      logic [MASK_W-1:0] m;
      for (int k = 0; k < MASK_W; k++) begin
         m[k] = (k < SENSORS_PER_BOARD);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gpc_front.sv
// ----------------------------------------------------------------------------
// gpc_front
// Splits an accepted activity word into per-sensor commands, highest first.
// ----------------------------------------------------------------------------
`default_nettype none

module gpc_front import gpc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [BOARD_W-1:0] board_number,
   input  wire logic [MASK_W-1:0]  activity_mask,
   input  wire logic [TIME_W-1:0]  event_time_ms,
   input  wire logic               fifo_full,
   output logic                    push,
   output cmd_type                 cmd
);

   front_state_type          state_ff, state_in;
   logic [BOARD_W-1:0]       board_ff, board_in;
   logic [TIME_W-1:0]        time_ff, time_in;
   logic [MASK_W-1:0]        mask_ff, mask_in;

   logic [MASK_IDX_W-1:0]    top_idx;
   logic [MASK_W-1:0]        rest_mask;

   // highest set bit
   always_comb begin
      top_idx = '0;
      for (int k = 0; k < MASK_W; k++) begin
         if (mask_ff[k]) begin
            top_idx = MASK_IDX_W'(k);
         end
      end
      rest_mask = mask_ff & ~(MASK_W'(1) << top_idx);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (accept) begin
               state_in = FRONT_ISSUE;
            end
         end
         FRONT_ISSUE: begin
            if (!fifo_full && rest_mask == '0) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      push           = (state_ff == FRONT_ISSUE) && !fifo_full;
      cmd.board      = board_ff;
      cmd.sensor     = SENSOR_W'(top_idx) + SENSOR_W'(1);
      cmd.time_ms    = time_ff;
      cmd.has_sensor = |mask_ff;
      cmd.last       = (rest_mask == '0);
      board_in       = board_ff;
      time_in        = time_ff;
      mask_in        = mask_ff;
      if (state_ff == FRONT_IDLE && accept) begin
         board_in = board_number;
         time_in  = event_time_ms;
         mask_in  = activity_mask & sensor_bits();
      end else if (push) begin
         mask_in = rest_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      board_ff <= board_in;
      time_ff  <= time_in;
      mask_ff  <= mask_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/gpc_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gpc_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gpc_cmd_fifo import gpc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_data,
   input  wire logic    pop,
   output cmd_type      head,
   output logic         empty,
   output logic         full
);

   cmd_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + FIFO_IDX_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + FIFO_IDX_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ASSERT_IMPL(a_no_push_full, clock, reset, push, !full)
   `ASSERT_IMPL(a_no_pop_empty, clock, reset, pop, !empty)

endmodule

`default_nettype wire

FILE: rtl/core/gpc_back.sv
// ----------------------------------------------------------------------------
// gpc_back
// Runs per-sensor commands against the age-ordered pending event store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gpc_back import gpc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [TIME_W-1:0] window,
   input  wire logic              fifo_empty,
   input  wire cmd_type           fifo_head,
   output logic                   pop,
   output rsp_type                rsp
);

   back_state_type            state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [STORE_CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic                      found_ff, found_in;
   logic [STORE_IDX_W-1:0]    found_pos_ff, found_pos_in;
   logic [STORE_CNT_W-1:0]    count_ff, count_in;
   logic [NOW_W-1:0]          ent_now_ff, ent_now_in;
   logic [NOW_W-1:0]          ex_now_ff, ex_now_in;
   logic                      ovf_ff, ovf_in;
   logic [TOTAL_W-1:0]        entry_total_ff, entry_total_in;
   logic [TOTAL_W-1:0]        exit_total_ff, exit_total_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [BOARD_W-1:0]        st_board_ff [STORE_DEPTH];
   logic [BOARD_W-1:0]        st_board_in [STORE_DEPTH];
   logic [SENSOR_W-1:0]       st_sensor_ff [STORE_DEPTH];
   logic [SENSOR_W-1:0]       st_sensor_in [STORE_DEPTH];
   logic [TIME_W-1:0]         st_time_ff [STORE_DEPTH];
   logic [TIME_W-1:0]         st_time_in [STORE_DEPTH];

   logic                      drop_en, wr_en, emit;
   logic [STORE_IDX_W-1:0]    drop_pos, wr_pos, cur;
   logic [TIME_W-1:0]         gap;
   logic                      stale, match, upper_half, in_range;
   logic [SENSOR_W-1:0]       partner;

   assign rsp = rsp_ff;

   // current scan entry
   always_comb begin
      cur        = scan_idx_ff[STORE_IDX_W-1:0];
      in_range   = scan_idx_ff < count_ff;
      gap        = (cmd_ff.time_ms >= st_time_ff[cur]) ? cmd_ff.time_ms - st_time_ff[cur]
                                                        : st_time_ff[cur] - cmd_ff.time_ms;
      stale      = gap > window;
      partner    = SENSOR_W'(SENSORS_PER_BOARD + 1) - cmd_ff.sensor;
      match      = (st_board_ff[cur] == cmd_ff.board) && (st_sensor_ff[cur] == partner);
      upper_half = {cmd_ff.sensor, 1'b0} > (SENSOR_W + 1)'(SENSORS_PER_BOARD);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!fifo_empty && fifo_head.has_sensor) begin
               state_in = BACK_SCAN;
            end
         end
         BACK_SCAN: begin
            if (!in_range) begin
               state_in = BACK_APPLY;
            end
         end
         BACK_APPLY: state_in = BACK_IDLE;
         default:    state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      cmd_in         = cmd_ff;
      scan_idx_in    = scan_idx_ff;
      found_in       = found_ff;
      found_pos_in   = found_pos_ff;
      count_in       = count_ff;
      ent_now_in     = ent_now_ff;
      ex_now_in      = ex_now_ff;
      ovf_in         = ovf_ff;
      entry_total_in = entry_total_ff;
      exit_total_in  = exit_total_ff;
      drop_en        = 1'b0;
      drop_pos       = '0;
      wr_en          = 1'b0;
      wr_pos         = count_ff[STORE_IDX_W-1:0];
      emit           = 1'b0;
      rsp_in         = rsp_ff;
      rsp_in.strobe  = 1'b0;

      case (state_ff)
         BACK_IDLE: begin
            if (!fifo_empty) begin
               pop         = 1'b1;
               cmd_in      = fifo_head;
               scan_idx_in = '0;
               found_in    = 1'b0;
               // empty mask: report totals right away
               emit        = !fifo_head.has_sensor;
            end
         end
         BACK_SCAN: begin
            // purge and oldest-partner search in one pass
            if (in_range) begin
               if (stale) begin
                  drop_en  = 1'b1;
                  drop_pos = cur;
                  count_in = count_ff - STORE_CNT_W'(1);
               end else begin
                  if (!found_ff && match) begin
                     found_in     = 1'b1;
                     found_pos_in = cur;
                  end
                  scan_idx_in = scan_idx_ff + STORE_CNT_W'(1);
               end
            end
         end
         BACK_APPLY: begin
            if (found_ff) begin
               drop_en  = 1'b1;
               drop_pos = found_pos_ff;
               count_in = count_ff - STORE_CNT_W'(1);
               if (upper_half) begin
                  if (ent_now_ff != NOW_MAX) ent_now_in = ent_now_ff + NOW_W'(1);
                  if (entry_total_ff != TOTAL_MAX) begin
                     entry_total_in = entry_total_ff + TOTAL_W'(1);
                  end
               end else begin
                  if (ex_now_ff != NOW_MAX) ex_now_in = ex_now_ff + NOW_W'(1);
                  if (exit_total_ff != TOTAL_MAX) begin
                     exit_total_in = exit_total_ff + TOTAL_W'(1);
                  end
               end
            end else begin
               wr_en = 1'b1;
               if (count_ff == STORE_CNT_W'(STORE_DEPTH)) begin
                  // full: oldest out, new one at the tail
                  drop_en  = 1'b1;
                  drop_pos = '0;
                  wr_pos   = STORE_IDX_W'(STORE_DEPTH - 1);
                  ovf_in   = 1'b1;
               end else begin
                  count_in = count_ff + STORE_CNT_W'(1);
               end
            end
            emit = cmd_ff.last;
         end
         default: ;
      endcase

      if (emit) begin
         rsp_in.strobe         = 1'b1;
         rsp_in.entries_now    = ent_now_in;
         rsp_in.exits_now      = ex_now_in;
         rsp_in.entry_total    = entry_total_in;
         rsp_in.exit_total     = exit_total_in;
         rsp_in.store_overflow = ovf_in;
         ent_now_in            = '0;
         ex_now_in             = '0;
         ovf_in                = 1'b0;
      end
   end

   // store shift / write
   always_comb begin
      for (int j = 0; j < STORE_DEPTH; j++) begin
         st_board_in[j]  = st_board_ff[j];
         st_sensor_in[j] = st_sensor_ff[j];
         st_time_in[j]   = st_time_ff[j];
         if (j < STORE_DEPTH - 1) begin
            if (drop_en && STORE_IDX_W'(j) >= drop_pos) begin
               st_board_in[j]  = st_board_ff[j+1];
               st_sensor_in[j] = st_sensor_ff[j+1];
               st_time_in[j]   = st_time_ff[j+1];
            end
         end
         if (wr_en && STORE_IDX_W'(j) == wr_pos) begin
            st_board_in[j]  = cmd_ff.board;
            st_sensor_in[j] = cmd_ff.sensor;
            st_time_in[j]   = cmd_ff.time_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= BACK_IDLE;
         count_ff       <= '0;
         ent_now_ff     <= '0;
         ex_now_ff      <= '0;
         ovf_ff         <= 1'b0;
         entry_total_ff <= '0;
         exit_total_ff  <= '0;
         found_ff       <= 1'b0;
         rsp_ff         <= '0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         ent_now_ff     <= ent_now_in;
         ex_now_ff      <= ex_now_in;
         ovf_ff         <= ovf_in;
         entry_total_ff <= entry_total_in;
         exit_total_ff  <= exit_total_in;
         found_ff       <= found_in;
         rsp_ff         <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      scan_idx_ff  <= scan_idx_in;
      found_pos_ff <= found_pos_in;
      st_board_ff  <= st_board_in;
      st_sensor_ff <= st_sensor_in;
      st_time_ff   <= st_time_in;
   end

   `ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= STORE_CNT_W'(STORE_DEPTH))
   `ASSERT_IMPL(a_scan_bound, clock, reset, state_ff == BACK_SCAN, scan_idx_ff <= count_ff)

endmodule

`default_nettype wire

FILE: rtl/core/gate_pair_crossing_counter_core.sv
// ----------------------------------------------------------------------------
// gate_pair_crossing_counter_core
// Pairs mirrored gate sensor events into entry and exit crossing counts.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken on a rising edge with start high and busy
//   low (board, activity mask, millisecond time). busy stays high until that
//   transaction's single result has been strobed, so one item is in flight.
//   Output: rsp_strobe is high for exactly one cycle with the per-item
//   counts, the saturating running totals and the overflow flag. The
//   receiver cannot stall; the result is simply presented for that cycle.
//   Config: csr_wr_en writes csr_wr_data into the pair window; write it only
//   while busy is low.
//   Operation: the front splits the mask into per-sensor commands and queues
//   them; the back runs each one as a scan over the pending store (one entry
//   per cycle, purging stale events and finding the oldest partner) and then
//   an update step that pairs and counts or stores the event. The store holds
//   16 entries. busy drops the cycle after the strobe; an empty mask gives a
//   result with the totals only.
//   Reset: synchronous; empties the store, zeroes the totals and loads a
//   500 ms window. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module gate_pair_crossing_counter_core import gpc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_wr_en,
   input  wire logic [TIME_W-1:0]  csr_wr_data,
   // request
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [BOARD_W-1:0] req_board_number,
   input  wire logic [MASK_W-1:0]  req_activity_mask,
   input  wire logic [TIME_W-1:0]  req_event_time_ms,
   // response
   output logic                    rsp_strobe,
   output logic [NOW_W-1:0]        rsp_entries_now,
   output logic [NOW_W-1:0]        rsp_exits_now,
   output logic [TOTAL_W-1:0]      rsp_entry_total,
   output logic [TOTAL_W-1:0]      rsp_exit_total,
   output logic                    rsp_store_overflow
);

   logic [TIME_W-1:0] window_ff, window_in;
   logic              busy_ff, busy_in;
   logic              accept;

   logic              push, pop, fifo_empty, fifo_full;
   cmd_type           push_cmd, head_cmd;
   rsp_type           rsp;

   // one transaction in flight: set on accept, cleared by its result
   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   always_comb begin
      window_in = csr_wr_en ? csr_wr_data : window_ff;
      busy_in   = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (rsp.strobe) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         busy_ff   <= 1'b0;
      end else begin
         window_ff <= window_in;
         busy_ff   <= busy_in;
      end
   end

   // front: split the mask into per-sensor commands
   gpc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .board_number  (req_board_number),
      .activity_mask (req_activity_mask),
      .event_time_ms (req_event_time_ms),
      .fifo_full     (fifo_full),
      .push          (push),
      .cmd           (push_cmd)
   );

   gpc_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_cmd),
      .pop       (pop),
      .head      (head_cmd),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   // back: purge, pair and store against the pending events
   gpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .window     (window_ff),
      .fifo_empty (fifo_empty),
      .fifo_head  (head_cmd),
      .pop        (pop),
      .rsp        (rsp)
   );

   assign rsp_strobe         = rsp.strobe;
   assign rsp_entries_now    = rsp.entries_now;
   assign rsp_exits_now      = rsp.exits_now;
   assign rsp_entry_total    = rsp.entry_total;
   assign rsp_exit_total     = rsp.exit_total;
   assign rsp_store_overflow = rsp.store_overflow;

   `ASSERT_IMPL(a_rsp_in_flight, clock, reset, rsp.strobe, busy_ff)
   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy_ff)

endmodule

`default_nettype wire

FILE: tb/sv/gate_pair_crossing_counter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_pair_crossing_counter_core_test
// Self-checking bench for the gate pair crossing counter. Directed tests
// cover empty masks, full mirror masks, the window boundary, minute rollover,
// times above 59999, a full pending store and both window extremes. Random
// traffic follows, built mostly from mirrored sensor pairs on one board with
// random gaps. A local model of the pending store predicts every result.
// ----------------------------------------------------------------------------

module gate_pair_crossing_counter_core_test;
   import gpc_pkg::*;

   // one pending sensor event, as the block keeps it
   typedef struct packed {
      logic [BOARD_W-1:0]  board;
      logic [SENSOR_W-1:0] sensor;
      logic [TIME_W-1:0]   stamp;
   } pending_event_type;

   // the result fields of one transaction
   typedef struct packed {
      logic [NOW_W-1:0]   entries_now;
      logic [NOW_W-1:0]   exits_now;
      logic [TOTAL_W-1:0] entry_total;
      logic [TOTAL_W-1:0] exit_total;
      logic               store_overflow;
   } crossing_count_type;

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [TIME_W-1:0]  csr_wr_data;
   logic               start;
   logic               busy;
   logic [BOARD_W-1:0] req_board_number;
   logic [MASK_W-1:0]  req_activity_mask;
   logic [TIME_W-1:0]  req_event_time_ms;
   logic               rsp_strobe;
   logic [NOW_W-1:0]   rsp_entries_now;
   logic [NOW_W-1:0]   rsp_exits_now;
   logic [TOTAL_W-1:0] rsp_entry_total;
   logic [TOTAL_W-1:0] rsp_exit_total;
   logic               rsp_store_overflow;

   // model state: pending events in age order, oldest at the front
   pending_event_type  pending_events[$];
   logic [TOTAL_W-1:0] entry_sum   = '0;
   logic [TOTAL_W-1:0] exit_sum    = '0;
   logic [TIME_W-1:0]  window_ms   = WINDOW_RESET;

   // predicted counts, one per accepted transaction, in order
   crossing_count_type expected_counts[$];

   int fail_count  = 0;
   int burst_left  = 0;
   int time_cursor = 0;
   bit no_idle     = 1'b0;

   gate_pair_crossing_counter_core dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .start              (start),
      .busy               (busy),
      .req_board_number   (req_board_number),
      .req_activity_mask  (req_activity_mask),
      .req_event_time_ms  (req_event_time_ms),
      .rsp_strobe         (rsp_strobe),
      .rsp_entries_now    (rsp_entries_now),
      .rsp_exits_now      (rsp_exits_now),
      .rsp_entry_total    (rsp_entry_total),
      .rsp_exit_total     (rsp_exit_total),
      .rsp_store_overflow (rsp_store_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Crossing model. Sensors go from highest to lowest; each one first purges
   // every stale event (all of them, not just some), then looks for the
   // oldest mirror partner on the same board. Upper-half sensors close an
   // entry, lower-half ones an exit; a miss stores the event, pushing out the
   // oldest one when the store is full.
   // ------------------------------------------------------------------------
   function automatic crossing_count_type count_crossings(
      input logic [BOARD_W-1:0] board,
      input logic [MASK_W-1:0]  mask,
      input logic [TIME_W-1:0]  stamp
   );
      crossing_count_type res;
      pending_event_type  ev;
      int sensor, mate, i, found_at, gap, now_ms, then_ms;
      res    = '0;
      now_ms = int'(stamp);
      for (int k = SENSORS_PER_BOARD - 1; k >= 0; k--) begin
         if (k < MASK_W && mask[k]) begin
            sensor = k + 1;
            mate   = SENSORS_PER_BOARD + 1 - sensor;
            // plain absolute difference, no wrap at the minute boundary
            i = 0;
            while (i < pending_events.size()) begin
               then_ms = int'(pending_events[i].stamp);
               gap     = (now_ms >= then_ms) ? now_ms - then_ms : then_ms - now_ms;
               if (gap > int'(window_ms)) pending_events.delete(i);
               else i++;
            end
            found_at = -1;
            for (int j = 0; j < pending_events.size() && found_at < 0; j++) begin
               if (pending_events[j].board == board && pending_events[j].sensor == mate)
                  found_at = j;
            end
            if (found_at >= 0) begin
               pending_events.delete(found_at);
               // middle sensor of an odd board falls on the entry side
               if (sensor * 2 > SENSORS_PER_BOARD) begin
                  if (res.entries_now != NOW_MAX) res.entries_now++;
                  if (entry_sum != TOTAL_MAX) entry_sum++;
               end else begin
                  if (res.exits_now != NOW_MAX) res.exits_now++;
                  if (exit_sum != TOTAL_MAX) exit_sum++;
               end
            end else begin
               if (pending_events.size() >= STORE_DEPTH) begin
                  void'(pending_events.pop_front());
                  res.store_overflow = 1'b1;
               end
               ev.board  = board;
               ev.sensor = SENSOR_W'(sensor);
               ev.stamp  = stamp;
               pending_events.insert(pending_events.size(), ev);
            end
         end
      end
      res.entry_total = entry_sum;
      res.exit_total  = exit_sum;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   // One transaction: fields and start go out at a clock edge; it is taken
   // at the first later edge with busy low. start stays high on return so a
   // burst can follow without a dead cycle.
   task automatic send_gate_event(
      input logic [BOARD_W-1:0] board,
      input logic [MASK_W-1:0]  mask,
      input logic [TIME_W-1:0]  stamp
   );
      req_board_number  <= board;
      req_activity_mask <= mask;
      req_event_time_ms <= stamp;
      start             <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_counts.insert(expected_counts.size(), count_crossings(board, mask, stamp));
   endtask

   // Bursts of random length, then a short or long gap with start low.
   task automatic sender_gap();
      int idle;
      if (no_idle) return;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         idle       = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
         start <= 1'b0;
         repeat (idle) @(posedge clock);
      end
   endtask

   // Hold off until every result is back and the block has gone idle.
   task automatic wait_for_results();
      start <= 1'b0;
      while (expected_counts.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [TIME_W-1:0] ms);
      wait_for_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ms;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_ms = ms;
   endtask

   // ------------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------------
   task automatic test_empty_and_mirror_masks();
      send_gate_event(4'd0, 8'h00, 16'd0);       // nothing happens, totals only
      send_gate_event(4'd5, 8'h0F, 16'd1000);    // stores sensors 4..1
      send_gate_event(4'd5, 8'hF0, 16'd1200);    // four entries
      send_gate_event(4'd6, 8'hFF, 16'd1300);    // 8..5 stored, 4..1 pair: four exits
      send_gate_event(4'd2, 8'h01, 16'd1400);
      send_gate_event(4'd3, 8'h80, 16'd1400);    // other board, no pair
   endtask

   task automatic test_window_boundary();
      send_gate_event(4'd1, 8'h02, 16'd10000);
      send_gate_event(4'd1, 8'h40, 16'd10500);   // gap equals window: entry
      send_gate_event(4'd1, 8'h04, 16'd20000);
      send_gate_event(4'd1, 8'h20, 16'd20501);   // one past the window: purged
   endtask

   task automatic test_time_wrap();
      send_gate_event(4'd15, 8'h01, 16'd59990);
      send_gate_event(4'd15, 8'h80, 16'd5);      // no wrap at the minute
      send_gate_event(4'd15, 8'h08, 16'd65400);  // out-of-range times still pair
      send_gate_event(4'd15, 8'h10, 16'd65535);
   endtask

   task automatic test_store_full();
      // upper sensors only, so nothing pairs: 4 stored per transaction
      repeat (5) send_gate_event(4'd7, 8'hF0, 16'd40000);
   endtask

   task automatic test_window_extremes();
      write_window(16'd0);
      send_gate_event(4'd4, 8'h01, 16'd30000);
      send_gate_event(4'd4, 8'h80, 16'd30000);   // same millisecond still pairs
      send_gate_event(4'd4, 8'h01, 16'd30000);
      send_gate_event(4'd4, 8'h80, 16'd30001);
      write_window(16'hFFFF);
      send_gate_event(4'd9, 8'h01, 16'd0);
      send_gate_event(4'd9, 8'h80, 16'd65535);   // widest gap with widest window
   endtask

   // ------------------------------------------------------------------------
   // Random traffic: mostly a mask then its mirror on the same board, with
   // random gaps around the window; the rest is loose noise.
   // ------------------------------------------------------------------------
   task automatic run_random_traffic(input int count);
      int sent, pick, gap, span;
      logic [BOARD_W-1:0] board;
      logic [MASK_W-1:0]  mask, mirror;
      logic [TIME_W-1:0]  t0;
      sent = 0;
      while (sent < count) begin
         pick        = $urandom_range(0, 99);
         board       = BOARD_W'($urandom_range(0, 15));
         mask        = MASK_W'($urandom_range(0, 255));
         time_cursor = (time_cursor + $urandom_range(0, 300)) % 65536;
         t0          = TIME_W'(time_cursor);
         if (pick < 60) begin
            if ($urandom_range(0, 2) != 0) mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            // mask covers exactly one board's sensors: reverse it for the partners
            for (int k = 0; k < MASK_W; k++) mirror[k] = mask[MASK_W - 1 - k];
            span = (window_ms < 16'd2000) ? int'(window_ms) + 2 : 2000;
            gap  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3000) : $urandom_range(0, span);
            send_gate_event(board, mask, t0);
            sender_gap();
            if ($urandom_range(0, 5) == 0) begin
               send_gate_event(BOARD_W'($urandom_range(0, 15)), MASK_W'($urandom_range(0, 255)), t0);
               sender_gap();
               sent++;
            end
            if ($urandom_range(0, 1) == 0) t0 = t0 + TIME_W'(gap);
            else t0 = t0 - TIME_W'(gap);
            // now and then a broken pair: the same sensors fire twice
            if ($urandom_range(0, 9) == 0) mirror = mask;
            send_gate_event(board, mirror, t0);
            sent += 2;
         end else if (pick < 85) begin
            send_gate_event(board, mask, t0);
            sent++;
         end else begin
            send_gate_event(board, mask, TIME_W'($urandom_range(0, 65535)));
            sent++;
         end
         sender_gap();
      end
   endtask

   task automatic test_random_traffic();
      write_window(WINDOW_RESET);
      run_random_traffic(300);
      wait_for_results();          // full drain in the middle of traffic
      run_random_traffic(300);
      write_window(TIME_W'($urandom_range(1, 1999)));
      run_random_traffic(450);
      write_window(16'd0);
      run_random_traffic(200);
      write_window(16'hFFFF);
      no_idle = 1'b1;              // back-to-back stretch, store stays full
      run_random_traffic(300);
      no_idle = 1'b0;
      write_window(TIME_W'($urandom_range(100, 800)));
      run_random_traffic(250);
   endtask

   // ------------------------------------------------------------------------
   // Result checker: every strobe must match the oldest prediction.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      crossing_count_type want;
      if (!reset && rsp_strobe) begin
         if (expected_counts.size() == 0) begin
            report_mismatch("result strobe with no transaction pending", 1, 0);
         end else begin
            want = expected_counts.pop_front();
            if (rsp_entries_now !== want.entries_now)
               report_mismatch("entries_now", int'(rsp_entries_now), int'(want.entries_now));
            if (rsp_exits_now !== want.exits_now)
               report_mismatch("exits_now", int'(rsp_exits_now), int'(want.exits_now));
            if (rsp_entry_total !== want.entry_total)
               report_mismatch("entry_total", int'(rsp_entry_total), int'(want.entry_total));
            if (rsp_exit_total !== want.exit_total)
               report_mismatch("exit_total", int'(rsp_exit_total), int'(want.exit_total));
            if (rsp_store_overflow !== want.store_overflow)
               report_mismatch("store_overflow", int'(rsp_store_overflow),
                               int'(want.store_overflow));
         end
      end
   end

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      start             = 1'b0;
      req_board_number  = '0;
      req_activity_mask = '0;
      req_event_time_ms = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_mirror_masks();
      test_window_boundary();
      test_time_wrap();
      test_store_full();
      test_window_extremes();
      test_random_traffic();

      wait_for_results();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && expected_counts.size() == 0) begin
         $display("PASS gate_pair_crossing_counter_core");
      end else begin
         $display("FAIL gate_pair_crossing_counter_core");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #20_000_000;
      $display("timeout: %0d results still outstanding", expected_counts.size());
      $display("FAIL gate_pair_crossing_counter_core");
      $finish;
   end

endmodule
